// ===== rtl/scv_pkg.sv =====
package scv_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int NUM_AXES = 3;
  localparam int COORD_W = 32;
  localparam int WIDTH_W = 31;
  localparam int FACTOR_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [14:0] FLAT_MAG = 15'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH_X = 3'd0,
    REG_CELL_WIDTH_Y = 3'd1,
    REG_CELL_WIDTH_Z = 3'd2,
    REG_HALF_TRANS_X = 3'd3,
    REG_HALF_TRANS_Y = 3'd4,
    REG_HALF_TRANS_Z = 3'd5,
    REG_AMPLITUDE    = 3'd6,
    REG_NONE         = 3'd7
  } cfg_reg_t;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];

  // one floor-division step for an axis
  typedef struct packed {
    logic [WIDTH_W-1:0] rem;
    logic [COORD_W-1:0] dvd;
    logic               neg;
    logic               q;
  } div_step_t;

  // one step of the taper index division
  typedef struct packed {
    logic [WIDTH_W-1:0]    rem;
    logic [SINE_IDX_W-1:0] idx;
    logic                  flat;
    logic                  odd;
  } tap_step_t;

  // quarter-wave entry: round(32767 * sin(pi/2 * i / depth)) by Taylor series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x, x2, term, pos, neg, v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      pos = x;
      neg = 64'd0;
      term = ((term * x2) >> 30) / 64'd6;
      neg = neg + term;
      term = ((term * x2) >> 30) / 64'd20;
      pos = pos + term;
      term = ((term * x2) >> 30) / 64'd42;
      neg = neg + term;
      term = ((term * x2) >> 30) / 64'd72;
      pos = pos + term;
      term = ((term * x2) >> 30) / 64'd110;
      neg = neg + term;
      term = ((term * x2) >> 30) / 64'd156;
      pos = pos + term;
      if (neg >= pos) begin
        rom[i] = 15'd0;
      end else begin
        v = ((pos - neg) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        rom[i] = v[14:0];
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Q1.15 product, rounded half away from zero
  function automatic logic signed [FACTOR_W-1:0] mul_q15(
    input logic signed [FACTOR_W-1:0] a,
    input logic signed [FACTOR_W-1:0] b
  );
    logic signed [31:0] p;
    logic [31:0] m;
    logic [31:0] r;
    p = a * b;
    m = p[31] ? 32'(-p) : 32'(p);
    r = (m + 32'd16384) >> 15;
    return p[31] ? -$signed(r[FACTOR_W-1:0]) : $signed(r[FACTOR_W-1:0]);
  endfunction

endpackage

// ===== rtl/scv_in_if.sv =====
interface scv_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] x_offset;
  logic signed [31:0] y_offset;
  logic signed [31:0] z_offset;
  logic [31:0] background_velocity;

  modport source (output valid, x_offset, y_offset, z_offset, background_velocity,
                  input ready);
  modport sink (input valid, x_offset, y_offset, z_offset, background_velocity,
                output ready);
endinterface

// ===== rtl/scv_out_if.sv =====
interface scv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] velocity;
  logic signed [15:0] pattern_value;

  modport source (output valid, velocity, pattern_value, input ready);
  modport sink (input valid, velocity, pattern_value, output ready);
endinterface

// ===== rtl/smoothed_checkerboard_velocity_top.sv =====
// Smoothed checkerboard velocity perturbation.
// Input channel in_ch carries one grid point per beat: x/y/z offsets from the
// checker origin (signed Q16.16) and the background velocity (unsigned Q16.16).
// Output channel out_ch returns one beat per input beat, in order: the
// perturbed velocity (Q16.16, saturated) and the three-axis pattern (Q1.15).
// Configuration registers are written through cfg_we/cfg_index/cfg_data while
// the block is empty; indexes past the amplitude register are ignored.
// The pipeline takes one beat per cycle while the skid register is empty; its
// depth is set by the 32 one-bit steps of the per-axis floor divider plus the
// 8 steps of the taper index divider.
// When the receiver stalls, the output register holds its beat and one more
// beat drops into a skid register; only then does in_ch.ready fall and the
// whole pipeline freeze, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults:
// cell widths 1.0, half transitions 0.125, amplitude about 0.05.
module smoothed_checkerboard_velocity_top (
  input  logic                           clk,
  input  logic                           rst_n,
  scv_in_if.sink                         in_ch,
  scv_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [scv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scv_pkg::WIDTH_W-1:0]    cfg_data
);

  localparam int DIV_STEPS = scv_pkg::COORD_W;
  localparam int TAP_STEPS = scv_pkg::SINE_IDX_W;
  localparam int S_RES = DIV_STEPS + 1;
  localparam int S_ZONE = S_RES + 1;
  localparam int S_FACT = S_ZONE + TAP_STEPS + 1;
  localparam int S_MYZ = S_FACT + 1;
  localparam int S_MX = S_MYZ + 1;
  localparam int S_FAC = S_MX + 1;
  localparam int S_PROD = S_FAC + 1;
  localparam int S_SAT = S_PROD + 1;
  localparam int NST = S_SAT + 1;
  localparam int NAX = scv_pkg::NUM_AXES;
  localparam int WW = scv_pkg::WIDTH_W;

  // configuration
  logic [WW-1:0]        cw_r [NAX];
  logic [WW-1:0]        ht_r [NAX];
  logic signed [15:0]   amp_r;
  logic [WW-1:0]        weff [NAX];
  logic [WW-1:0]        teff [NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NAX; a++) begin
        cw_r[a] <= WW'(65536);
        ht_r[a] <= WW'(8192);
      end
      amp_r <= 16'sd1638;
    end else if (cfg_we) begin
      case (scv_pkg::cfg_reg_t'(cfg_index))
        scv_pkg::REG_CELL_WIDTH_X: cw_r[0] <= cfg_data;
        scv_pkg::REG_CELL_WIDTH_Y: cw_r[1] <= cfg_data;
        scv_pkg::REG_CELL_WIDTH_Z: cw_r[2] <= cfg_data;
        scv_pkg::REG_HALF_TRANS_X: ht_r[0] <= cfg_data;
        scv_pkg::REG_HALF_TRANS_Y: ht_r[1] <= cfg_data;
        scv_pkg::REG_HALF_TRANS_Z: ht_r[2] <= cfg_data;
        scv_pkg::REG_AMPLITUDE:    amp_r <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      weff[a] = (cw_r[a] == '0) ? WW'(1) : cw_r[a];
      teff[a] = (ht_r[a] == '0) ? WW'(1) : ht_r[a];
    end
  end

  // pipeline control
  logic [NST-1:0] v_r;
  logic           skid_v_r;
  logic           out_v_r;
  logic           adv;
  logic           in_acc;
  logic           out_take;

  assign adv      = !skid_v_r;
  assign in_ch.ready = adv;
  assign in_acc   = in_ch.valid && adv;
  assign out_take = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_acc};
    end
  end

  // payload registers
  scv_pkg::div_step_t   div_r [NAX][DIV_STEPS+1];
  scv_pkg::div_step_t   div_nxt [NAX][DIV_STEPS];
  logic [WW-1:0]        res_r [NAX];
  logic                 res_odd_r [NAX];
  scv_pkg::tap_step_t   tap_r [NAX][TAP_STEPS+1];
  scv_pkg::tap_step_t   tap_nxt [NAX][TAP_STEPS];
  scv_pkg::tap_step_t   zone_nxt [NAX];
  logic signed [15:0]   fact_r [NAX];
  logic signed [15:0]   myz_r;
  logic signed [15:0]   fx_r;
  logic signed [15:0]   pat_r [S_MX:S_SAT];
  logic [31:0]          fac_r;
  logic [63:0]          prod_r;
  logic [31:0]          vel_r;
  logic [31:0]          bg_r [S_SAT];
  logic [31:0]          in_coord [NAX];

  assign in_coord[0] = in_ch.x_offset;
  assign in_coord[1] = in_ch.y_offset;
  assign in_coord[2] = in_ch.z_offset;

  // floor-division steps: restoring, one quotient bit per stage
  always_comb begin
    logic [WW:0] sh;
    logic        ge;
    for (int a = 0; a < NAX; a++) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        sh = {div_r[a][k].rem, div_r[a][k].dvd[DIV_STEPS-1]};
        ge = (sh >= {1'b0, weff[a]});
        div_nxt[a][k].rem = ge ? WW'(sh - {1'b0, weff[a]}) : sh[WW-1:0];
        div_nxt[a][k].dvd = {div_r[a][k].dvd[DIV_STEPS-2:0], 1'b0};
        div_nxt[a][k].neg = div_r[a][k].neg;
        div_nxt[a][k].q   = ge;
      end
    end
  end

  // zone choice and taper index steps
  always_comb begin
    logic [WW-1:0] wmr;
    logic          lo;
    logic          hi;
    logic [WW:0]   sh;
    logic          ge;
    for (int a = 0; a < NAX; a++) begin
      wmr = weff[a] - res_r[a];
      lo  = res_r[a] < teff[a];
      hi  = wmr < teff[a];
      zone_nxt[a].rem  = lo ? res_r[a] : wmr;
      zone_nxt[a].idx  = '0;
      zone_nxt[a].flat = !lo && !hi;
      zone_nxt[a].odd  = res_odd_r[a];
      for (int k = 0; k < TAP_STEPS; k++) begin
        sh = {tap_r[a][k].rem, 1'b0};
        ge = (sh >= {1'b0, teff[a]});
        tap_nxt[a][k].rem  = ge ? WW'(sh - {1'b0, teff[a]}) : sh[WW-1:0];
        tap_nxt[a][k].idx  = {tap_r[a][k].idx[TAP_STEPS-2:0], ge};
        tap_nxt[a][k].flat = tap_r[a][k].flat;
        tap_nxt[a][k].odd  = tap_r[a][k].odd;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [14:0] mag;
    logic signed [31:0] ap;
    logic [34:0] vr;
    if (adv) begin
      bg_r[0] <= in_ch.background_velocity;
      for (int s = 1; s < S_SAT; s++) begin
        bg_r[s] <= bg_r[s-1];
      end
      for (int a = 0; a < NAX; a++) begin
        // hold the magnitude; the sign resolves after the last step
        div_r[a][0].rem <= '0;
        div_r[a][0].dvd <= in_coord[a][31] ? 32'(-in_coord[a]) : in_coord[a];
        div_r[a][0].neg <= in_coord[a][31];
        div_r[a][0].q   <= 1'b0;
        for (int k = 0; k < DIV_STEPS; k++) begin
          div_r[a][k+1] <= div_nxt[a][k];
        end
        // negative offsets: floor moves one cell down when the remainder is nonzero
        if (div_r[a][DIV_STEPS].neg && div_r[a][DIV_STEPS].rem != '0) begin
          res_r[a]     <= weff[a] - div_r[a][DIV_STEPS].rem;
          res_odd_r[a] <= !div_r[a][DIV_STEPS].q;
        end else begin
          res_r[a]     <= div_r[a][DIV_STEPS].rem;
          res_odd_r[a] <= div_r[a][DIV_STEPS].q;
        end
        tap_r[a][0] <= zone_nxt[a];
        for (int k = 0; k < TAP_STEPS; k++) begin
          tap_r[a][k+1] <= tap_nxt[a][k];
        end
        mag = tap_r[a][TAP_STEPS].flat ? scv_pkg::FLAT_MAG
                                       : scv_pkg::SINE_ROM[tap_r[a][TAP_STEPS].idx];
        fact_r[a] <= tap_r[a][TAP_STEPS].odd ? -$signed({1'b0, mag})
                                             : $signed({1'b0, mag});
      end
      myz_r <= scv_pkg::mul_q15(fact_r[2], fact_r[1]);
      fx_r  <= fact_r[0];
      pat_r[S_MX] <= scv_pkg::mul_q15(myz_r, fx_r);
      for (int s = S_MX + 1; s <= S_SAT; s++) begin
        pat_r[s] <= pat_r[s-1];
      end
      ap = amp_r * pat_r[S_MX];
      fac_r  <= 32'(scv_pkg::Q30_ONE) + 32'(ap);
      prod_r <= 64'(bg_r[S_FAC]) * 64'(fac_r);
      vr = 35'((prod_r + (scv_pkg::Q30_ONE >> 1)) >> 30);
      vel_r <= (vr[34:32] != 3'd0) ? 32'hFFFF_FFFF : vr[31:0];
    end
  end

  // output register and skid stage
  logic [31:0]        out_vel_r;
  logic signed [15:0] out_pat_r;
  logic [31:0]        skid_vel_r;
  logic signed [15:0] skid_pat_r;
  logic               incoming;

  assign incoming = adv && v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_take) begin
      out_v_r <= incoming;
    end else if (incoming) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_vel_r <= skid_vel_r;
        out_pat_r <= skid_pat_r;
      end
    end else if (!out_v_r || out_take) begin
      out_vel_r <= vel_r;
      out_pat_r <= pat_r[S_SAT];
    end else begin
      skid_vel_r <= vel_r;
      skid_pat_r <= pat_r[S_SAT];
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.velocity      = out_vel_r;
  assign out_ch.pattern_value = out_pat_r;

  // skid only fills behind a stalled output beat
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_pat_r != 16'sh8000)
    else $error("pattern value out of range");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(v_r))
    else $error("pipeline advanced while skid was full");

endmodule
